// ===== rtl/core/c2s_pkg.sv =====
// Shared constants, types and tables for the cartesian to spherical converter.
`timescale 1ns / 1ps

package c2s_pkg;

    // Default field widths and CORDIC depth.
    localparam int COORD_WIDTH   = 24;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    // Extra fraction bits carried through the CORDIC magnitudes.
    localparam int GUARD_BITS = 16;

    // CORDIC gain in Q30, used to scale |z| into the stage-one magnitude domain.
    localparam int GAIN_WIDTH = 31;
    localparam int GAIN_FRAC  = 30;
    localparam logic [GAIN_WIDTH-1:0] GAIN_Q30 = 31'd1768195363;

    // Angle accumulator: 32-bit turn units plus sign and headroom.
    localparam int ACC_WIDTH = 34;
    localparam logic signed [ACC_WIDTH-1:0] ACC_QUARTER_TURN = 34'sd1073741824;

    // atan(2^-i) in units of 2^-32 turn, rounded to nearest.
    localparam logic [31:0] ATAN_TURN32 [32] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1,         32'd1,         32'd0
    };

    // Sign and zero information of one request, carried down the pipeline.
    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic z_zero;
        logic x_neg;
        logic y_neg;
        logic z_neg;
    } c2s_flags_t;

endpackage

// ===== rtl/core/c2s_delay.sv =====
// Enable-gated delay line that aligns side data with the pipeline.
`timescale 1ns / 1ps

module c2s_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0)
        begin : g_none
            assign dout = din;
        end
        else
        begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];

            // Shift one place on every pipeline advance.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= din;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign dout = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ===== rtl/core/c2s_sqrt.sv =====
// Pipelined sum of squares and rounded integer square root, one result bit per stage.
`timescale 1ns / 1ps

module c2s_sqrt #(
    parameter int COORD_WIDTH = c2s_pkg::COORD_WIDTH
) (
    input  logic                   clk,
    input  logic                   en,
    input  logic [COORD_WIDTH-1:0] abs_x,
    input  logic [COORD_WIDTH-1:0] abs_y,
    input  logic [COORD_WIDTH-1:0] abs_z,
    output logic [COORD_WIDTH-1:0] root
);

    localparam int SW = 2 * COORD_WIDTH;   // sum of three squares fits here
    localparam int RW = COORD_WIDTH + 3;   // partial remainder width

    logic [SW-1:0] sqx_reg, sqy_reg, sqz_reg;
    logic [SW-1:0] sum_reg;
    logic [RW-1:0] rem_reg  [COORD_WIDTH];
    logic [COORD_WIDTH-1:0] root_reg [COORD_WIDTH];
    logic [SW-1:0] n_reg    [COORD_WIDTH];
    logic [COORD_WIDTH-1:0] root_out_reg;
    logic [COORD_WIDTH-1:0] root_next;

    // Squares, then their sum, each behind a register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= abs_x * abs_x;
            sqy_reg <= abs_y * abs_y;
            sqz_reg <= abs_z * abs_z;
            sum_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    // Restoring square root: each stage brings down two radicand bits.
    genvar k;
    generate
        for (k = 0; k < COORD_WIDTH; k++)
        begin : g_step
            logic [RW-1:0]          rem_in;
            logic [COORD_WIDTH-1:0] root_in;
            logic [SW-1:0]          n_in;
            logic [RW-1:0]          rem_sh;
            logic [RW-1:0]          trial;
            logic                   fits;

            if (k == 0)
            begin : g_first
                assign rem_in  = '0;
                assign root_in = '0;
                assign n_in    = sum_reg;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign n_in    = n_reg[k-1];
            end

            assign rem_sh = {rem_in[RW-3:0], n_in[SW-1:SW-2]};
            assign trial  = RW'({root_in, 2'b01});
            assign fits   = (rem_sh >= trial);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= fits ? (rem_sh - trial) : rem_sh;
                    root_reg[k] <= {root_in[COORD_WIDTH-2:0], fits};
                    n_reg[k]    <= {n_in[SW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    // Round to nearest: bump the root when the remainder exceeds it.
    always_comb
    begin
        root_next = root_reg[COORD_WIDTH-1];
        if (rem_reg[COORD_WIDTH-1] > RW'(root_reg[COORD_WIDTH-1]))
        begin
            root_next = root_reg[COORD_WIDTH-1] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_out_reg <= root_next;
        end
    end

    assign root = root_out_reg;

endmodule

// ===== rtl/core/c2s_cordic.sv =====
// Unrolled CORDIC vectoring pipeline giving a first-quadrant angle and the final x.
`timescale 1ns / 1ps

module c2s_cordic #(
    parameter int STAGES      = c2s_pkg::CORDIC_STAGES,
    parameter int DATA_WIDTH  = 45,
    parameter int ANGLE_WIDTH = c2s_pkg::ANGLE_WIDTH
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [DATA_WIDTH-1:0]  a_in,
    input  logic signed [DATA_WIDTH-1:0]  b_in,
    output logic [ANGLE_WIDTH-1:0]        angle,
    output logic signed [DATA_WIDTH-1:0]  mag
);

    localparam int AW = c2s_pkg::ACC_WIDTH;
    localparam logic [30:0] ROUND_HALF = 31'(64'd1 << (31 - ANGLE_WIDTH));

    logic signed [DATA_WIDTH-1:0] x_reg   [STAGES];
    logic signed [DATA_WIDTH-1:0] y_reg   [STAGES];
    logic signed [AW-1:0]         acc_reg [STAGES];

    logic [ANGLE_WIDTH-1:0]       angle_reg, angle_next;
    logic signed [DATA_WIDTH-1:0] mag_reg;
    logic signed [AW-1:0]         acc_last;
    logic [30:0]                  clamp;
    logic [30:0]                  rounded;

    // One micro-rotation per stage, driving y toward zero.
    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_stage
            logic signed [DATA_WIDTH-1:0] xs, ys;
            logic signed [AW-1:0]         as;
            logic signed [AW-1:0]         step;

            if (k == 0)
            begin : g_first
                assign xs = a_in;
                assign ys = b_in;
                assign as = '0;
            end
            else
            begin : g_rest
                assign xs = x_reg[k-1];
                assign ys = y_reg[k-1];
                assign as = acc_reg[k-1];
            end

            assign step = $signed({{(AW - 32){1'b0}}, c2s_pkg::ATAN_TURN32[k]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!ys[DATA_WIDTH-1])
                    begin
                        x_reg[k]   <= xs + (ys >>> k);
                        y_reg[k]   <= ys - (xs >>> k);
                        acc_reg[k] <= as + step;
                    end
                    else
                    begin
                        x_reg[k]   <= xs - (ys >>> k);
                        y_reg[k]   <= ys + (xs >>> k);
                        acc_reg[k] <= as - step;
                    end
                end
            end
        end
    endgenerate

    // Clamp to the range from zero to one quarter turn and round to the output angle width.
    always_comb
    begin
        acc_last = acc_reg[STAGES-1];
        if (acc_last[AW-1])
        begin
            clamp = '0;
        end
        else if (acc_last > c2s_pkg::ACC_QUARTER_TURN)
        begin
            clamp = 31'(c2s_pkg::ACC_QUARTER_TURN);
        end
        else
        begin
            clamp = acc_last[30:0];
        end
        rounded    = clamp + ROUND_HALF;
        angle_next = {1'b0, rounded[30:32-ANGLE_WIDTH]};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
            mag_reg   <= x_reg[STAGES-1];
        end
    end

    assign angle = angle_reg;
    assign mag   = mag_reg;

endmodule

// ===== rtl/core/cartesian_to_spherical.sv =====
// Top level of the pipelined cartesian to spherical converter.
`timescale 1ns / 1ps

// Converts one signed (x, y, z) vector per clock, unless stalled, into radius,
// polar angle and azimuth. A new request can be taken every cycle while
// req_stall is low. The square root, one result bit per stage, runs beside
// the two chained CORDIC pipelines. The whole pipeline holds while the
// result register is full and stalled. Angles are unsigned fractions of a
// turn with 2^ANGLE_WIDTH equal to a full turn; a zero vector raises
// zero_vector and reports all other fields as zero.
module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH   = c2s_pkg::ANGLE_WIDTH,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [COORD_WIDTH-1:0]        radius,
    output logic [ANGLE_WIDTH-1:0]        polar_angle,
    output logic [ANGLE_WIDTH-1:0]        azimuth,
    output logic                          zero_vector
);

    localparam int GB      = c2s_pkg::GUARD_BITS;
    localparam int DW      = COORD_WIDTH + GB + 5;
    localparam int ZS_LSB  = c2s_pkg::GAIN_FRAC - GB;
    localparam int PROD_W  = COORD_WIDTH + c2s_pkg::GAIN_WIDTH;
    localparam int ZS_W    = PROD_W - ZS_LSB;
    localparam int LAT_ANG = 2 * CORDIC_STAGES + 2;
    localparam int LAT_SQ  = COORD_WIDTH + 3;
    localparam int LAT     = (LAT_ANG > LAT_SQ) ? LAT_ANG : LAT_SQ;
    localparam int FLAG_W  = $bits(c2s_pkg::c2s_flags_t);

    localparam logic [ANGLE_WIDTH-1:0] HALF    = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 1));
    localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(64'd1 << (ANGLE_WIDTH - 2));
    localparam logic [ANGLE_WIDTH-1:0] THREE_Q = HALF + QUARTER;

    logic advance;

    // Input stage: magnitudes and sign/zero flags.
    logic [COORD_WIDTH-1:0] ax_reg, ay_reg, az_reg;
    c2s_pkg::c2s_flags_t    flags_reg;
    c2s_pkg::c2s_flags_t    flags_next;

    // Valid bits, one per pipeline stage up to the aligned point.
    logic [LAT:0] vld_reg;
    logic         res_valid_reg;

    logic [COORD_WIDTH-1:0] radius_reg;
    logic [ANGLE_WIDTH-1:0] polar_reg, azimuth_reg;
    logic                   zero_reg;
    logic [ANGLE_WIDTH-1:0] polar_next, azimuth_next;
    logic                   zero_next;

    logic [PROD_W-1:0]      zprod;
    logic signed [DW-1:0]   zs_reg;
    logic signed [DW-1:0]   zs_dly;
    logic signed [DW-1:0]   c1_a, c1_b;
    logic [ANGLE_WIDTH-1:0] q_ang, q_dly;
    logic signed [DW-1:0]   rho;
    logic [ANGLE_WIDTH-1:0] t_ang, t_dly;
    logic signed [DW-1:0]   t_mag;
    logic [COORD_WIDTH-1:0] root, root_dly;
    logic [FLAG_W-1:0]      flags_dly;
    c2s_pkg::c2s_flags_t    fl;

    // The pipeline moves whenever the result register can take a new value.
    assign advance   = !res_valid_reg || !res_stall;
    assign req_stall = !advance;

    always_comb
    begin
        flags_next.x_zero = (coord_x == '0);
        flags_next.y_zero = (coord_y == '0);
        flags_next.z_zero = (coord_z == '0);
        flags_next.x_neg  = coord_x[COORD_WIDTH-1];
        flags_next.y_neg  = coord_y[COORD_WIDTH-1];
        flags_next.z_neg  = coord_z[COORD_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ax_reg    <= coord_x[COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
            ay_reg    <= coord_y[COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;
            az_reg    <= coord_z[COORD_WIDTH-1] ? (~coord_z + 1'b1) : coord_z;
            flags_reg <= flags_next;
        end
    end

    // Valid chain and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg       <= {vld_reg[LAT-1:0], req_valid};
            res_valid_reg <= vld_reg[LAT];
        end
    end

    // Radius.
    c2s_sqrt #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_sqrt (
        .clk   (clk),
        .en    (advance),
        .abs_x (ax_reg),
        .abs_y (ay_reg),
        .abs_z (az_reg),
        .root  (root)
    );

    c2s_delay #(
        .WIDTH (COORD_WIDTH),
        .DEPTH (LAT - LAT_SQ)
    ) u_root_dly (
        .clk  (clk),
        .en   (advance),
        .din  (root),
        .dout (root_dly)
    );

    // |z| scaled by the CORDIC gain, then held until stage one finishes.
    assign zprod = az_reg * c2s_pkg::GAIN_Q30;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            zs_reg <= $signed(DW'(zprod[PROD_W-1:ZS_LSB]));
        end
    end

    c2s_delay #(
        .WIDTH (DW),
        .DEPTH (CORDIC_STAGES)
    ) u_zs_dly (
        .clk  (clk),
        .en   (advance),
        .din  (zs_reg),
        .dout (zs_dly)
    );

    // Stage one: azimuth in the first quadrant and the x-y magnitude.
    assign c1_a = $signed(DW'({ax_reg, {GB{1'b0}}}));
    assign c1_b = $signed(DW'({ay_reg, {GB{1'b0}}}));

    c2s_cordic #(
        .STAGES      (CORDIC_STAGES),
        .DATA_WIDTH  (DW),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cordic_xy (
        .clk   (clk),
        .en    (advance),
        .a_in  (c1_a),
        .b_in  (c1_b),
        .angle (q_ang),
        .mag   (rho)
    );

    // Stage two: polar angle from scaled |z| and the x-y magnitude.
    c2s_cordic #(
        .STAGES      (CORDIC_STAGES),
        .DATA_WIDTH  (DW),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_cordic_rz (
        .clk   (clk),
        .en    (advance),
        .a_in  (zs_dly),
        .b_in  (rho),
        .angle (t_ang),
        .mag   (t_mag)
    );

    c2s_delay #(
        .WIDTH (ANGLE_WIDTH),
        .DEPTH (LAT - CORDIC_STAGES - 1)
    ) u_q_dly (
        .clk  (clk),
        .en   (advance),
        .din  (q_ang),
        .dout (q_dly)
    );

    c2s_delay #(
        .WIDTH (ANGLE_WIDTH),
        .DEPTH (LAT - LAT_ANG)
    ) u_t_dly (
        .clk  (clk),
        .en   (advance),
        .din  (t_ang),
        .dout (t_dly)
    );

    c2s_delay #(
        .WIDTH (FLAG_W),
        .DEPTH (LAT)
    ) u_flags_dly (
        .clk  (clk),
        .en   (advance),
        .din  (flags_reg),
        .dout (flags_dly)
    );

    // Quadrant and axis resolution.
    assign fl = c2s_pkg::c2s_flags_t'(flags_dly);

    always_comb
    begin
        zero_next = fl.x_zero && fl.y_zero && fl.z_zero;

        priority if (fl.x_zero && fl.y_zero)
        begin
            azimuth_next = '0;
        end
        else if (fl.x_zero)
        begin
            azimuth_next = fl.y_neg ? THREE_Q : QUARTER;
        end
        else if (fl.y_zero)
        begin
            azimuth_next = fl.x_neg ? HALF : '0;
        end
        else if (!fl.x_neg && !fl.y_neg)
        begin
            azimuth_next = q_dly;
        end
        else if (fl.x_neg && !fl.y_neg)
        begin
            azimuth_next = HALF - q_dly;
        end
        else if (fl.x_neg)
        begin
            azimuth_next = HALF + q_dly;
        end
        else
        begin
            azimuth_next = '0 - q_dly;
        end

        priority if (zero_next)
        begin
            polar_next = '0;
        end
        else if (fl.x_zero && fl.y_zero)
        begin
            polar_next = fl.z_neg ? HALF : '0;
        end
        else if (fl.z_zero)
        begin
            polar_next = QUARTER;
        end
        else if (fl.z_neg)
        begin
            polar_next = HALF - t_dly;
        end
        else
        begin
            polar_next = t_dly;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            radius_reg  <= root_dly;
            polar_reg   <= polar_next;
            azimuth_reg <= azimuth_next;
            zero_reg    <= zero_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign radius      = radius_reg;
    assign polar_angle = polar_reg;
    assign azimuth     = azimuth_reg;
    assign zero_vector = zero_reg;

endmodule

// ===== tb/sv/cartesian_to_spherical_tb.sv =====
// Self-checking testbench for the cartesian to spherical converter.
`timescale 1ns / 1ps

module cartesian_to_spherical_tb;

    localparam int CW = c2s_pkg::COORD_WIDTH;
    localparam int AW = c2s_pkg::ANGLE_WIDTH;
    localparam int LATENCY = 40;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_LEN = 200;
    localparam logic [AW-1:0] FULL_TURN_M1 = '1;
    localparam logic [AW:0] FULL_TURN = {1'b1, {AW{1'b0}}};

    typedef struct {
        logic [CW-1:0] radius;
        logic [AW-1:0] polar;
        logic [AW-1:0] azim;
        logic          zero;
    } sph_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic signed [CW-1:0] coord_z = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [CW-1:0] radius;
    logic [AW-1:0] polar_angle;
    logic [AW-1:0] azimuth;
    logic zero_vector;

    sph_t expected_q[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_cycles = 0;
    int quiet_cycles = 0;

    cartesian_to_spherical u_dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .res_valid(res_valid), .res_stall(res_stall),
        .radius(radius), .polar_angle(polar_angle),
        .azimuth(azimuth), .zero_vector(zero_vector)
    );

    always #5 clk = ~clk;

    // Shift toward minus infinity.
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    // Rounded integer square root.
    function automatic longint unsigned root_rounded(longint unsigned n);
        longint unsigned res, bits;
        res = 0;
        bits = 64'd1 << 62;
        while (bits > n) bits >>= 2;
        while (bits != 0)
        begin
            if (n >= res + bits)
            begin
                n -= res + bits;
                res = (res >> 1) + bits;
            end
            else
                res >>= 1;
            bits >>= 2;
        end
        if (n > res) res += 1;
        return res;
    endfunction

    // CORDIC vectoring of (a, b): angle in 2^-32 turns, final x in mag.
    function automatic longint unsigned cordic_angle(longint a, longint b, output longint mag);
        longint x, y, acc, dx, dy;
        x = a;
        y = b;
        acc = 0;
        for (int i = 0; i < c2s_pkg::CORDIC_STAGES; i++)
        begin
            dx = floor_shr(y, i & 31);
            dy = floor_shr(x, i & 31);
            if (y >= 0)
            begin
                x += dx; y -= dy; acc += longint'(c2s_pkg::ATAN_TURN32[i & 31]);
            end
            else
            begin
                x -= dx; y += dy; acc -= longint'(c2s_pkg::ATAN_TURN32[i & 31]);
            end
        end
        if (acc < 0) acc = 0;
        if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
        mag = x;
        return acc;
    endfunction

    function automatic longint unsigned turn_to_angle(longint unsigned t);
        return (t + (64'd1 << (31 - AW))) >> (32 - AW);
    endfunction

    // Expected spherical coordinates of one vector.
    function automatic sph_t spherical_of(logic signed [CW-1:0] cx,
                                          logic signed [CW-1:0] cy,
                                          logic signed [CW-1:0] cz);
        sph_t r;
        longint x, y, z, rho, spare, zs;
        longint unsigned ax, ay, az, q, a, half, quarter, phi, theta;
        x = cx; y = cy; z = cz;
        ax = x < 0 ? -x : x;
        ay = y < 0 ? -y : y;
        az = z < 0 ? -z : z;
        half = FULL_TURN >> 1;
        quarter = FULL_TURN >> 2;
        r.radius = CW'(root_rounded(ax * ax + ay * ay + az * az));
        r.zero = 1'b0;
        rho = 0;
        phi = 0;
        if (x == 0 && y == 0 && z == 0)
        begin
            r.radius = '0; r.polar = '0; r.azim = '0; r.zero = 1'b1;
            return r;
        end
        if (x != 0 || y != 0)
        begin
            q = turn_to_angle(cordic_angle(ax << c2s_pkg::GUARD_BITS,
                                           ay << c2s_pkg::GUARD_BITS, rho));
            if (x == 0) phi = (y > 0) ? quarter : 3 * quarter;
            else if (y == 0) phi = (x > 0) ? 0 : half;
            else if (x > 0 && y > 0) phi = q;
            else if (x < 0 && y > 0) phi = half - q;
            else if (x < 0) phi = half + q;
            else phi = FULL_TURN - q;
        end
        if (rho == 0) theta = (z > 0) ? 0 : half;
        else if (z == 0) theta = quarter;
        else
        begin
            zs = (az * longint'(c2s_pkg::GAIN_Q30)) >>
                 (c2s_pkg::GAIN_FRAC - c2s_pkg::GUARD_BITS);
            a = turn_to_angle(cordic_angle(zs, rho, spare));
            theta = (z > 0) ? a : half - a;
        end
        r.polar = AW'(theta & FULL_TURN_M1);
        r.azim = AW'(phi & FULL_TURN_M1);
        return r;
    endfunction

    // Send one request; valid stays high across back-to-back requests.
    task automatic send_vector(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        expected_q.insert(expected_q.size(), spherical_of(x, y, z));
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic go_idle();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(5))
            0: return CW'(int'($urandom_range(8)) - 4);
            1: return CW'(int'($urandom_range(2000)) - 1000);
            2: return {$urandom_range(1) ? {CW{1'b1}} : {CW{1'b0}}};
            3: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, or a long counted hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_cycles <= HOLD_LEN;
            res_stall <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        sph_t e;
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("ERROR: unexpected result r=%0d", radius);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (radius !== e.radius || polar_angle !== e.polar ||
                        azimuth !== e.azim || zero_vector !== e.zero)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                            $display("ERROR: exp r=%0d th=%0d ph=%0d z=%0b got r=%0d th=%0d ph=%0d z=%0b",
                                     e.radius, e.polar, e.azim, e.zero,
                                     radius, polar_angle, azimuth, zero_vector);
                    end
                end
            end
        end
    end

    // Extremes, axes, zero vector and the x-y plane.
    task automatic test_directed();
        logic signed [CW-1:0] mx, mn;
        mx = {1'b0, {(CW-1){1'b1}}};
        mn = {1'b1, {(CW-1){1'b0}}};
        send_vector(0, 0, 0);
        send_vector(0, 0, 5);
        send_vector(0, 0, -5);
        send_vector(7, 0, 0);
        send_vector(-7, 0, 0);
        send_vector(0, 9, 0);
        send_vector(0, -9, 0);
        send_vector(3, 4, 0);
        send_vector(-3, -4, 12);
        send_vector(mx, mx, mx);
        send_vector(mn, mn, mn);
        send_vector(mn, mx, mn);
        send_vector(mx, mn, 0);
        send_vector(1, -1, mn);
        send_vector(-1, 1, mx);
        send_vector(mn, 0, 0);
        send_vector(0, 0, mn);
        send_vector(100, -200, 300);
        send_vector(-1, -1, -1);
        go_idle();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_vector(rand_coord(), rand_coord(), rand_coord());
        go_idle();
    endtask

    // Hold the output off long enough that the pipeline fills and backs up.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = hold_req + 1;
        repeat (120) send_vector(rand_coord(), rand_coord(), rand_coord());
        go_idle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300, 0, 0);
        test_random(300, 69, 0);
        test_random(300, 0, 69);
        test_random(300, 24, 24);
        test_backpressure();
        test_random(200, 0, 0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
